>>> design/assert_macros.svh
// assertion helpers included by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/ebpg_pkg.sv
// ----------------------------------------------------------------------------
// ebpg_pkg
// Shared widths, constants, sequencer states and control types of the
// even beat pattern generator.
// ----------------------------------------------------------------------------
package ebpg_pkg;

    localparam int PAT_W = 48;
    localparam int LEN_W = 6;

    localparam logic [LEN_W-1:0] MAX_STEPS = 6'd48;

    typedef logic [PAT_W-1:0] t_pat;
    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_FILLX,
        ST_FILLY,
        ST_ROT
    } t_state;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_PAIR,
        CMD_FILLX,
        CMD_FILLY,
        CMD_ROT
    } t_cmd;

    typedef struct packed {
        logic pair_more;
        logic fillx_more;
        logic filly_more;
        logic mod_done;
    } t_sts;

endpackage

>>> design/ebpg_seq.sv
// ----------------------------------------------------------------------------
// ebpg_seq
// Sequencer: steps the shared shift unit through pairing, group fill and
// rotation for one request.
// ----------------------------------------------------------------------------
module ebpg_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ebpg_pkg::t_sts i_sts,
    output ebpg_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ebpg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_PAIR;
                end
            end
            ST_PAIR: begin
                if (i_sts.pair_more) begin
                    o_cmd = CMD_PAIR;
                end else begin
                    n_state = ST_FILLX;
                end
            end
            ST_FILLX: begin
                if (i_sts.fillx_more) begin
                    o_cmd = CMD_FILLX;
                end else begin
                    n_state = ST_FILLY;
                end
            end
            ST_FILLY: begin
                if (i_sts.filly_more) begin
                    o_cmd = CMD_FILLY;
                end else begin
                    n_state = ST_ROT;
                end
            end
            ST_ROT: begin
                // wait for the offset reduction to finish
                if (i_sts.mod_done) begin
                    o_cmd   = CMD_ROT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/ebpg_dp.sv
// ----------------------------------------------------------------------------
// ebpg_dp
// Datapath: group registers, one shared left shifter, offset reduction and
// the output registers.
// ----------------------------------------------------------------------------
module ebpg_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ebpg_pkg::t_cmd i_cmd,
    input  ebpg_pkg::t_len i_step_count,
    input  ebpg_pkg::t_len i_beat_count,
    input  ebpg_pkg::t_len i_rotate_offset,
    output ebpg_pkg::t_sts o_sts,
    output logic           o_valid,
    output ebpg_pkg::t_pat o_beat_pattern,
    output ebpg_pkg::t_len o_pattern_length
);
    import ebpg_pkg::*;

    t_pat r_xbits;
    t_pat r_ybits;
    t_len r_xlen;
    t_len r_ylen;
    t_len r_xcnt;
    t_len r_ycnt;
    t_len r_steps;
    t_len r_off;
    t_len r_pos;
    t_pat r_pat;
    t_pat r_out_pat;
    t_len r_out_len;
    logic r_valid;

    t_len n_steps;
    t_len n_beats;
    t_pat sh_in;
    t_len sh_amt;
    t_pat sh_out;
    t_pat len_mask;
    t_pat rot_pat;

    // request clamping
    always_comb begin
        if (i_step_count == '0) begin
            n_steps = t_len'(1);
        end else if (i_step_count > MAX_STEPS) begin
            n_steps = MAX_STEPS;
        end else begin
            n_steps = i_step_count;
        end
        n_beats = (i_beat_count > n_steps) ? n_steps : i_beat_count;
    end

    // shared shift unit
    always_comb begin
        case (i_cmd)
            CMD_PAIR: begin
                sh_in  = r_ybits;
                sh_amt = r_xlen;
            end
            CMD_FILLX: begin
                sh_in  = r_xbits;
                sh_amt = r_pos;
            end
            CMD_FILLY: begin
                sh_in  = r_ybits;
                sh_amt = r_pos;
            end
            default: begin
                sh_in  = '0;
                sh_amt = '0;
            end
        endcase
        sh_out = sh_in << sh_amt;
    end

    assign len_mask = ~({PAT_W{1'b1}} << r_steps);
    assign rot_pat  = ((r_pat >> r_off) | (r_pat << (r_steps - r_off))) & len_mask;

    assign o_sts.pair_more  = (r_xcnt > t_len'(1)) && (r_ycnt > t_len'(1));
    assign o_sts.fillx_more = (r_xcnt != '0);
    assign o_sts.filly_more = (r_ycnt != '0);
    assign o_sts.mod_done   = (r_off < r_steps);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd == CMD_ROT);
        end
    end

    always_ff @(posedge i_clk) begin
        // offset reduction runs alongside the group work
        if (i_cmd != CMD_LOAD && r_off >= r_steps) begin
            r_off <= r_off - r_steps;
        end
        case (i_cmd)
            CMD_LOAD: begin
                r_steps <= n_steps;
                r_off   <= i_rotate_offset;
                r_xcnt  <= n_beats;
                r_ycnt  <= n_steps - n_beats;
                r_xbits <= t_pat'(1);
                r_ybits <= '0;
                r_xlen  <= t_len'(1);
                r_ylen  <= t_len'(1);
                r_pos   <= '0;
                r_pat   <= '0;
            end
            CMD_PAIR: begin
                if (r_xcnt >= r_ycnt) begin
                    r_xcnt  <= r_ycnt;
                    r_ycnt  <= r_xcnt - r_ycnt;
                    r_ybits <= r_xbits;
                    r_ylen  <= r_xlen;
                end else begin
                    r_ycnt <= r_ycnt - r_xcnt;
                end
                r_xbits <= r_xbits | sh_out;
                r_xlen  <= r_xlen + r_ylen;
            end
            CMD_FILLX: begin
                r_pat  <= r_pat | sh_out;
                r_pos  <= r_pos + r_xlen;
                r_xcnt <= r_xcnt - t_len'(1);
            end
            CMD_FILLY: begin
                r_pat  <= r_pat | sh_out;
                r_pos  <= r_pos + r_ylen;
                r_ycnt <= r_ycnt - t_len'(1);
            end
            CMD_ROT: begin
                r_out_pat <= rot_pat;
                r_out_len <= r_steps;
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_valid;
    assign o_beat_pattern   = r_out_pat;
    assign o_pattern_length = r_out_len;

endmodule

>>> design/even_beat_pattern_generator.sv
// ----------------------------------------------------------------------------
// even_beat_pattern_generator
// Builds an evenly spread beat pattern from step count, beat count and
// rotation offset, one request at a time.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low. The block then
// stays busy while one shared shifter runs the pairing rounds, lays the
// final groups into the pattern and rotates it. o_valid pulses for one
// cycle with the result once the groups are laid and the offset reduction
// (one subtract per cycle) has finished; busy drops in that same cycle. The
// slowest request is a one-step pattern with offset 63. The result must be
// captured in its strobe cycle: there is no way to hold it.
module even_beat_pattern_generator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ebpg_pkg::t_len i_step_count,
    input  ebpg_pkg::t_len i_beat_count,
    input  ebpg_pkg::t_len i_rotate_offset,
    output logic           o_valid,
    output ebpg_pkg::t_pat o_beat_pattern,
    output ebpg_pkg::t_len o_pattern_length
);
    import ebpg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ebpg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ebpg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_step_count     (i_step_count),
        .i_beat_count     (i_beat_count),
        .i_rotate_offset  (i_rotate_offset),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_beat_pattern   (o_beat_pattern),
        .o_pattern_length (o_pattern_length)
    );

`include "assert_macros.svh"

    `ASSERT_SAME(a_len_range, i_clk, i_rst_n, o_valid, (o_pattern_length != '0) && (o_pattern_length <= MAX_STEPS))
    `ASSERT_SAME(a_no_bits_above_len, i_clk, i_rst_n, o_valid, (o_beat_pattern >> o_pattern_length) == '0)
    `ASSERT_SAME(a_idle_on_result, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_single_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy && !o_valid)

endmodule

>>> verif/even_beat_pattern_generator_tb.sv
// ----------------------------------------------------------------------------
// even_beat_pattern_generator_tb
// Drives step, beat and rotation requests through the start/busy handshake,
// predicts each pattern with a local pairing model and checks every result
// strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
module even_beat_pattern_generator_tb;

    import ebpg_pkg::*;

    typedef struct {
        t_len steps;
        t_len beats;
        t_len offs;
        t_pat pattern;
        t_len length;
    } t_rhythm;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_len i_step_count = '0;
    t_len i_beat_count = '0;
    t_len i_rotate_offset = '0;
    logic o_valid;
    t_pat o_beat_pattern;
    t_len o_pattern_length;

    t_rhythm pending_patterns[$];
    int      mismatch_count = 0;
    int      idle_pct = 37;

    even_beat_pattern_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_step_count    (i_step_count),
        .i_beat_count    (i_beat_count),
        .i_rotate_offset (i_rotate_offset),
        .o_valid         (o_valid),
        .o_beat_pattern  (o_beat_pattern),
        .o_pattern_length(o_pattern_length)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    // pairing model: groups are bit strings with the first step in bit 0
    function automatic t_rhythm predict_rhythm(input t_len steps_in, input t_len beats_in,
                                               input t_len offs_in);
        logic [63:0] x_grp, y_grp, old_y, pat, mask;
        int unsigned x_len, y_len, x_num, y_num, n, beats, rot, pos, tmp, old_y_len, i;
        t_rhythm r;
        n = steps_in;
        if (n == 0) n = 1;
        if (n > MAX_STEPS) n = MAX_STEPS;
        beats = beats_in;
        if (beats > n) beats = n;
        x_grp = 64'd1;
        y_grp = 64'd0;
        x_len = 1;
        y_len = 1;
        x_num = beats;
        y_num = n - beats;
        while (x_num > 1 && y_num > 1) begin
            old_y = y_grp;
            old_y_len = y_len;
            if (x_num >= y_num) begin
                tmp = x_num;
                x_num = y_num;
                y_num = tmp - y_num;
                y_grp = x_grp;
                y_len = x_len;
            end else begin
                y_num = y_num - x_num;
            end
            x_grp = x_grp | (old_y << x_len);
            x_len = x_len + old_y_len;
        end
        pat = '0;
        pos = 0;
        for (i = 0; i < x_num && pos < 64; i++) begin
            pat |= x_grp << pos;
            pos += x_len;
        end
        for (i = 0; i < y_num && pos < 64; i++) begin
            pat |= y_grp << pos;
            pos += y_len;
        end
        mask = (64'd1 << n) - 64'd1;
        pat &= mask;
        rot = offs_in % n;
        if (rot != 0) pat = ((pat >> rot) | (pat << (n - rot))) & mask;
        r.steps = steps_in;
        r.beats = beats_in;
        r.offs = offs_in;
        r.pattern = pat[PAT_W-1:0];
        r.length = n[LEN_W-1:0];
        return r;
    endfunction

    // start may drop in any cycle; a transfer is start high with busy low at the edge
    task automatic send_request(input t_len steps, input t_len beats, input t_len offs);
        logic drive;
        forever begin
            drive = (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
            start <= drive;
            if (drive) begin
                i_step_count <= steps;
                i_beat_count <= beats;
                i_rotate_offset <= offs;
            end else begin
                i_step_count <= t_len'($urandom);
                i_beat_count <= t_len'($urandom);
                i_rotate_offset <= t_len'($urandom);
            end
            @(posedge i_clk);
            if (drive && !busy) break;
        end
        pending_patterns.push_back(predict_rhythm(steps, beats, offs));
    endtask

    always @(posedge i_clk) begin
        t_rhythm want;
        if (i_rst_n && o_valid) begin
            if (pending_patterns.size() == 0) begin
                report_mismatch($sformatf("unexpected result pattern=%h length=%0d",
                                          o_beat_pattern, o_pattern_length));
            end else begin
                want = pending_patterns.pop_front();
                if (o_beat_pattern !== want.pattern)
                    report_mismatch($sformatf("steps=%0d beats=%0d offset=%0d pattern %h, want %h",
                                              want.steps, want.beats, want.offs,
                                              o_beat_pattern, want.pattern));
                if (o_pattern_length !== want.length)
                    report_mismatch($sformatf("steps=%0d beats=%0d offset=%0d length %0d, want %0d",
                                              want.steps, want.beats, want.offs,
                                              o_pattern_length, want.length));
            end
        end
    end

    task automatic send_random_batch(input int count);
        t_len steps, beats, offs;
        int   sel;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                // whole field range, out-of-range lengths included
                steps = t_len'($urandom);
                beats = t_len'($urandom);
                offs = t_len'($urandom);
            end else begin
                steps = t_len'($urandom_range(48, 1));
                if (sel < 22) beats = t_len'($urandom_range(63, steps));
                else beats = t_len'($urandom_range(steps, 0));
                offs = t_len'($urandom_range(63));
            end
            send_request(steps, beats, offs);
        end
    endtask

    task automatic test_edge_cases();
        idle_pct = 37;
        send_request(6'd1, 6'd0, 6'd0);
        send_request(6'd1, 6'd1, 6'd0);
        send_request(6'd0, 6'd0, 6'd0);
        send_request(6'd0, 6'd5, 6'd7);
        send_request(6'd48, 6'd0, 6'd0);
        send_request(6'd48, 6'd48, 6'd0);
        send_request(6'd48, 6'd63, 6'd63);
        send_request(6'd63, 6'd20, 6'd5);
        send_request(6'd49, 6'd1, 6'd0);
        send_request(6'd63, 6'd63, 6'd63);
        send_request(6'd8, 6'd3, 6'd0);
        send_request(6'd8, 6'd3, 6'd2);
        send_request(6'd8, 6'd3, 6'd8);
        send_request(6'd8, 6'd3, 6'd63);
        send_request(6'd16, 6'd5, 6'd17);
        send_request(6'd13, 6'd5, 6'd0);
        send_request(6'd12, 6'd7, 6'd3);
        send_request(6'd47, 6'd46, 6'd1);
        send_request(6'd48, 6'd1, 6'd47);
        send_request(6'd48, 6'd47, 6'd48);
        send_request(6'd2, 6'd1, 6'd1);
        send_request(6'd24, 6'd11, 6'd30);
        send_request(6'd7, 6'd63, 6'd0);
        send_request(6'd1, 6'd63, 6'd63);
    endtask

    task automatic test_random_with_gaps();
        idle_pct = 37;
        send_random_batch(650);
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        send_random_batch(300);
    endtask

    initial begin
        int waited;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_random_with_gaps();
        test_back_to_back();
        start <= 1'b0;

        waited = 0;
        while (pending_patterns.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        while (pending_patterns.size() != 0) begin
            t_rhythm lost;
            lost = pending_patterns.pop_front();
            report_mismatch($sformatf("no result for steps=%0d beats=%0d offset=%0d",
                                      lost.steps, lost.beats, lost.offs));
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
